>>> src/tjs_pkg.sv
`default_nettype none
package tjs_pkg;

    localparam int MAX_JOBS_DEF    = 16;
    localparam int TIME_BITS_DEF   = 24;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int SLOT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int QUANTUM_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SRTF = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

    localparam logic [COUNT_W-1:0]   COUNT_RESET   = 5'd1;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd500;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_we;
        logic tick_begin;
        logic prep_step;
        logic scan_issue;
        logic apply;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic start_ge_n;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

>>> src/tjs_ram.sv
`default_nettype none
module tjs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/tjs_ctrl.sv
`default_nettype none
module tjs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_req_type,
    output logic                   s_ready,
    input  wire tjs_pkg::status_t  status,
    output tjs_pkg::cmd_t          cmd
);
    tjs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tjs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            tjs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == tjs_pkg::REQ_TICK) begin
                        cmd.tick_begin = 1'b1;
                        state_next     = tjs_pkg::ST_PREP;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            tjs_pkg::ST_PREP: begin
                if (status.n_zero) begin
                    state_next = tjs_pkg::ST_APPLY;
                end else if (status.start_ge_n) begin
                    cmd.prep_step = 1'b1;
                end else begin
                    state_next = tjs_pkg::ST_SCAN;
                end
            end
            tjs_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = tjs_pkg::ST_DRAIN;
                end
            end
            tjs_pkg::ST_DRAIN: begin
                state_next = tjs_pkg::ST_APPLY;
            end
            tjs_pkg::ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = tjs_pkg::ST_OUT;
            end
            tjs_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = tjs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tjs_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/tjs_datapath.sv
`default_nettype none
module tjs_datapath #(
    parameter int MAX_JOBS    = tjs_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS   = tjs_pkg::TIME_BITS_DEF,
    parameter int LENGTH_BITS = tjs_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [tjs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tjs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [tjs_pkg::SLOT_W-1:0]        s_slot,
    input  wire logic [TIME_BITS-1:0]              s_arrival_time,
    input  wire logic [LENGTH_BITS-1:0]            s_run_length,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tjs_pkg::SLOT_W-1:0]             m_running_slot,
    output logic                                   m_idle,
    output logic                                   m_job_finished,
    output logic                                   m_all_finished,
    output logic [TIME_BITS-1:0]                   m_now_time,
    input  wire tjs_pkg::cmd_t                     cmd,
    output tjs_pkg::status_t                       status
);
    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    // configuration
    logic [tjs_pkg::MODE_W-1:0]    mode_reg;
    logic [tjs_pkg::COUNT_W-1:0]   count_reg;
    logic [tjs_pkg::QUANTUM_W-1:0] quantum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= tjs_pkg::MODE_FIFO;
            count_reg   <= tjs_pkg::COUNT_RESET;
            quantum_reg <= tjs_pkg::QUANTUM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tjs_pkg::REG_POLICY:  mode_reg    <= cfg_data[tjs_pkg::MODE_W-1:0];
                tjs_pkg::REG_COUNT:   count_reg   <= cfg_data[tjs_pkg::COUNT_W-1:0];
                tjs_pkg::REG_QUANTUM: quantum_reg <= cfg_data[tjs_pkg::QUANTUM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] n;
    assign n = (32'(count_reg) > 32'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : CNT_W'(count_reg);

    // scheduler state
    logic [TIME_BITS-1:0]          clock_reg;
    logic [IDX_W-1:0]              cur_reg, cur_next;
    logic                          active_reg, active_next;
    logic [tjs_pkg::QUANTUM_W-1:0] slice_reg, slice_next;
    logic [CNT_W-1:0]              start_reg;

    // scan bookkeeping
    logic [IDX_W-1:0]       issue_idx_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [CNT_W-1:0]       nz_reg;
    logic                   fifo_found_reg, fifo_ok_reg;
    logic [IDX_W-1:0]       fifo_idx_reg;
    logic [LENGTH_BITS-1:0] fifo_rem_reg;
    logic                   sj_found_reg;
    logic [IDX_W-1:0]       sj_idx_reg;
    logic [LENGTH_BITS-1:0] sj_rem_reg;
    logic                   hi_found_reg, lo_found_reg;
    logic [IDX_W-1:0]       hi_idx_reg, lo_idx_reg;
    logic [LENGTH_BITS-1:0] hi_rem_reg, lo_rem_reg;
    logic [LENGTH_BITS-1:0] cur_rem_reg;

    // result staging
    logic [tjs_pkg::SLOT_W-1:0] res_slot_reg;
    logic                       res_idle_reg, res_done_reg, res_all_reg;

    // memories
    logic                   load_ok;
    logic [IDX_W-1:0]       load_addr;
    logic [TIME_BITS-1:0]   arr_rdata;
    logic [LENGTH_BITS-1:0] rem_rdata;
    logic                   rem_we;
    logic [IDX_W-1:0]       rem_waddr;
    logic [LENGTH_BITS-1:0] rem_wdata;

    assign load_ok   = 32'(s_slot) < 32'(MAX_JOBS);
    assign load_addr = IDX_W'(s_slot);

    tjs_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_JOBS)) u_arr_ram (
        .aclk  (aclk),
        .we    (cmd.load_we && load_ok),
        .waddr (load_addr),
        .wdata (s_arrival_time),
        .raddr (issue_idx_reg),
        .rdata (arr_rdata)
    );

    tjs_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_JOBS)) u_rem_ram (
        .aclk  (aclk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (issue_idx_reg),
        .rdata (rem_rdata)
    );

    // per slot evaluation of the returning read
    logic rd_nz, rd_ready;
    assign rd_nz    = rem_rdata != '0;
    assign rd_ready = rd_nz && (arr_rdata <= clock_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_issue;
        end
        rd_idx_reg <= issue_idx_reg;
        if (cmd.tick_begin) begin
            issue_idx_reg  <= '0;
            start_reg      <= active_reg ? CNT_W'(cur_reg) + CNT_W'(1) : CNT_W'(cur_reg);
            nz_reg         <= '0;
            fifo_found_reg <= 1'b0;
            sj_found_reg   <= 1'b0;
            hi_found_reg   <= 1'b0;
            lo_found_reg   <= 1'b0;
            cur_rem_reg    <= '0;
        end else begin
            if (cmd.prep_step) begin
                start_reg <= start_reg - n;
            end
            if (cmd.scan_issue) begin
                issue_idx_reg <= issue_idx_reg + IDX_W'(1);
            end
            if (rd_vld_reg) begin
                if (rd_nz) begin
                    nz_reg <= nz_reg + CNT_W'(1);
                end
                if (rd_nz && !fifo_found_reg) begin
                    fifo_found_reg <= 1'b1;
                    fifo_ok_reg    <= rd_ready;
                    fifo_idx_reg   <= rd_idx_reg;
                    fifo_rem_reg   <= rem_rdata;
                end
                if (rd_ready && (!sj_found_reg || rem_rdata < sj_rem_reg)) begin
                    sj_found_reg <= 1'b1;
                    sj_idx_reg   <= rd_idx_reg;
                    sj_rem_reg   <= rem_rdata;
                end
                if (rd_ready && !lo_found_reg) begin
                    lo_found_reg <= 1'b1;
                    lo_idx_reg   <= rd_idx_reg;
                    lo_rem_reg   <= rem_rdata;
                end
                if (rd_ready && !hi_found_reg && (CNT_W'(rd_idx_reg) >= start_reg)) begin
                    hi_found_reg <= 1'b1;
                    hi_idx_reg   <= rd_idx_reg;
                    hi_rem_reg   <= rem_rdata;
                end
                if (rd_idx_reg == cur_reg) begin
                    cur_rem_reg <= rem_rdata;
                end
            end
        end
    end

    // selection
    logic                          held_ok, run, done, all_fin;
    logic [IDX_W-1:0]              sel;
    logic [LENGTH_BITS-1:0]        sel_rem, new_rem;
    logic [tjs_pkg::QUANTUM_W-1:0] slice_eff, slice_dec;
    logic                          rr_held;

    assign held_ok = active_reg && (CNT_W'(cur_reg) < n) && (cur_rem_reg != '0);
    assign rr_held = held_ok && (slice_reg != '0);

    always_comb begin
        run     = 1'b0;
        sel     = '0;
        sel_rem = '0;
        unique case (mode_reg)
            tjs_pkg::MODE_FIFO: begin
                run     = fifo_found_reg && fifo_ok_reg;
                sel     = fifo_idx_reg;
                sel_rem = fifo_rem_reg;
            end
            tjs_pkg::MODE_SJF: begin
                if (held_ok) begin
                    run     = 1'b1;
                    sel     = cur_reg;
                    sel_rem = cur_rem_reg;
                end else begin
                    run     = sj_found_reg;
                    sel     = sj_idx_reg;
                    sel_rem = sj_rem_reg;
                end
            end
            tjs_pkg::MODE_SRTF: begin
                run     = sj_found_reg;
                sel     = sj_idx_reg;
                sel_rem = sj_rem_reg;
            end
            tjs_pkg::MODE_RR: begin
                if (rr_held) begin
                    run     = 1'b1;
                    sel     = cur_reg;
                    sel_rem = cur_rem_reg;
                end else if (hi_found_reg) begin
                    run     = 1'b1;
                    sel     = hi_idx_reg;
                    sel_rem = hi_rem_reg;
                end else begin
                    run     = lo_found_reg;
                    sel     = lo_idx_reg;
                    sel_rem = lo_rem_reg;
                end
            end
            default: ;
        endcase
    end

    assign new_rem   = sel_rem - LENGTH_BITS'(1);
    assign done      = run && (new_rem == '0);
    assign all_fin   = (nz_reg == '0) || ((nz_reg == CNT_W'(1)) && done);
    assign slice_eff = rr_held ? slice_reg
                     : ((quantum_reg == '0) ? tjs_pkg::QUANTUM_W'(1) : quantum_reg);
    assign slice_dec = slice_eff - tjs_pkg::QUANTUM_W'(1);

    always_comb begin
        active_next = active_reg;
        cur_next    = cur_reg;
        slice_next  = slice_reg;
        unique case (mode_reg)
            tjs_pkg::MODE_SJF: begin
                if (!held_ok) begin
                    active_next = run;
                    if (run) begin
                        cur_next = sel;
                    end
                end
                if (done) begin
                    active_next = 1'b0;
                end
            end
            tjs_pkg::MODE_RR: begin
                if (!rr_held) begin
                    active_next = run;
                    cur_next    = run ? sel : '0;
                end
                if (run) begin
                    slice_next = slice_dec;
                    if (done || slice_dec == '0) begin
                        active_next = 1'b0;
                        cur_next    = (CNT_W'(sel) + CNT_W'(1) == n) ? '0 : sel + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign rem_we    = (cmd.load_we && load_ok) || (cmd.apply && run);
    assign rem_waddr = cmd.load_we ? load_addr : sel;
    assign rem_wdata = cmd.load_we ? s_run_length : new_rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg  <= '0;
            cur_reg    <= '0;
            active_reg <= 1'b0;
            slice_reg  <= '0;
            m_valid    <= 1'b0;
        end else begin
            if (cmd.apply) begin
                cur_reg    <= cur_next;
                active_reg <= active_next;
                slice_reg  <= slice_next;
                if (clock_reg != '1) begin
                    clock_reg <= clock_reg + TIME_BITS'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            res_slot_reg <= run ? tjs_pkg::SLOT_W'(sel) : '0;
            res_idle_reg <= !run;
            res_done_reg <= done;
            res_all_reg  <= all_fin;
        end
        if (cmd.out_load) begin
            m_running_slot <= res_slot_reg;
            m_idle         <= res_idle_reg;
            m_job_finished <= res_done_reg;
            m_all_finished <= res_all_reg;
            m_now_time     <= clock_reg;
        end
    end

    assign status.n_zero     = n == '0;
    assign status.start_ge_n = start_reg >= n;
    assign status.scan_last  = CNT_W'(issue_idx_reg) + CNT_W'(1) == n;
    assign status.out_free   = !m_valid || m_ready;
endmodule
`default_nettype wire

>>> src/tick_job_scheduler.sv
// channel   direction  payload                                          transfer
// s_        in         req_type, slot, arrival_time, run_length         s_valid & s_ready
// m_        out        running_slot, idle, job_finished, all_finished,  m_valid & m_ready
//                      now_time
// cfg_      in         cfg_index, cfg_data                              cfg_we
//
// a tick scans the n slots in use, reading one slot a cycle from the job table memory
// before the scan, the scan start slot is folded into range by subtracting n, in every mode
// reset clears the clock and hold state and restores the default configuration; the job table is not cleared
// a finished result waits in the output register while loads keep transferring
`default_nettype none
module tick_job_scheduler #(
    parameter int MAX_JOBS    = tjs_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS   = tjs_pkg::TIME_BITS_DEF,
    parameter int LENGTH_BITS = tjs_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [tjs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tjs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic [tjs_pkg::SLOT_W-1:0]     s_slot,
    input  wire logic [TIME_BITS-1:0]           s_arrival_time,
    input  wire logic [LENGTH_BITS-1:0]         s_run_length,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [tjs_pkg::SLOT_W-1:0]          m_running_slot,
    output logic                                m_idle,
    output logic                                m_job_finished,
    output logic                                m_all_finished,
    output logic [TIME_BITS-1:0]                m_now_time
);
    tjs_pkg::cmd_t    cmd;
    tjs_pkg::status_t status;

    tjs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    tjs_datapath #(
        .MAX_JOBS    (MAX_JOBS),
        .TIME_BITS   (TIME_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_slot         (s_slot),
        .s_arrival_time (s_arrival_time),
        .s_run_length   (s_run_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_running_slot (m_running_slot),
        .m_idle         (m_idle),
        .m_job_finished (m_job_finished),
        .m_all_finished (m_all_finished),
        .m_now_time     (m_now_time),
        .cmd            (cmd),
        .status         (status)
    );

    // a tick transfer makes the block busy
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == tjs_pkg::REQ_TICK) |=> !s_ready)
        else $error("input still ready after tick transfer");

    // a load transfer keeps the block ready
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == tjs_pkg::REQ_LOAD) |=> s_ready)
        else $error("input not ready after load transfer");

    // an idle tick never reports a finished job
    a_idle_no_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_idle |-> !m_job_finished)
        else $error("idle result flags a finished job");
endmodule
`default_nettype wire

>>> tb/sv/tb_tick_job_scheduler.sv
`default_nettype none
module tb_tick_job_scheduler;

    typedef struct {
        logic [3:0]  slot;
        logic        idle;
        logic        fin;
        logic        all;
        logic [23:0] now;
    } tick_result_t;

    class sched_scoreboard;
        logic [1:0]   mode;
        logic [4:0]   cnt;
        logic [15:0]  quantum;
        logic [23:0]  arr[16];
        logic [15:0]  rem[16];
        logic [23:0]  clk_now;
        int           cur;
        bit           active;
        logic [15:0]  slice;
        tick_result_t pending[$];
        int           errors;
        int           ticks;
        int           loads;

        function new();
            mode = tjs_pkg::MODE_FIFO;
            cnt = tjs_pkg::COUNT_RESET;
            quantum = tjs_pkg::QUANTUM_RESET;
            clk_now = '0;
            cur = 0;
            active = 0;
            slice = '0;
            errors = 0;
            ticks = 0;
            loads = 0;
        endfunction

        function void set_reg(logic [tjs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
            if (idx == tjs_pkg::REG_POLICY) mode = d[1:0];
            else if (idx == tjs_pkg::REG_COUNT) cnt = d[4:0];
            else if (idx == tjs_pkg::REG_QUANTUM) quantum = d;
        endfunction

        function bit ready_at(int i);
            return arr[i] <= clk_now && rem[i] != 0;
        endfunction

        function bit pick_shortest(int n, output int sel);
            bit found;
            logic [15:0] best;
            found = 0;
            best = '0;
            sel = 0;
            for (int i = 0; i < n; i++) begin
                if (ready_at(i) && (!found || rem[i] < best)) begin
                    found = 1;
                    best = rem[i];
                    sel = i;
                end
            end
            return found;
        endfunction

        function void note_input(bit rt, logic [3:0] s, logic [23:0] a, logic [15:0] r);
            int n;
            int sel;
            int start;
            int idx;
            bit run;
            bit done;
            bit all;
            tick_result_t res;
            if (rt == tjs_pkg::REQ_LOAD) begin
                arr[s] = a;
                rem[s] = r;
                loads++;
                return;
            end
            ticks++;
            n = (cnt > 16) ? 16 : cnt;
            run = 0;
            sel = 0;
            done = 0;
            all = 1;
            case (mode)
                tjs_pkg::MODE_FIFO: begin
                    for (int i = 0; i < n; i++) begin
                        if (rem[i] != 0) begin
                            if (arr[i] <= clk_now) begin
                                run = 1;
                                sel = i;
                            end
                            break;
                        end
                    end
                end
                tjs_pkg::MODE_SJF: begin
                    if (active && cur < n && rem[cur] != 0) begin
                        run = 1;
                        sel = cur;
                    end else begin
                        active = 0;
                        run = pick_shortest(n, sel);
                        if (run) begin
                            active = 1;
                            cur = sel;
                        end
                    end
                end
                tjs_pkg::MODE_SRTF: run = pick_shortest(n, sel);
                default: begin
                    if (active && cur < n && rem[cur] != 0 && slice != 0) begin
                        run = 1;
                        sel = cur;
                    end else if (n != 0) begin
                        start = active ? (cur + 1) % n : cur % n;
                        active = 0;
                        for (int k = 0; k < n; k++) begin
                            idx = (start + k) % n;
                            if (ready_at(idx)) begin
                                run = 1;
                                sel = idx;
                                break;
                            end
                        end
                        if (run) begin
                            active = 1;
                            cur = sel;
                            slice = (quantum == 0) ? 16'd1 : quantum;
                        end else begin
                            cur = 0;
                        end
                    end else begin
                        active = 0;
                        cur = 0;
                    end
                end
            endcase
            if (run) begin
                rem[sel] = rem[sel] - 16'd1;
                done = rem[sel] == 0;
                if (mode == tjs_pkg::MODE_SJF && done) active = 0;
                if (mode == tjs_pkg::MODE_RR) begin
                    slice = slice - 16'd1;
                    if (done || slice == 0) begin
                        active = 0;
                        cur = (sel + 1) % n;
                    end
                end
            end
            if (clk_now != 24'hFFFFFF) clk_now = clk_now + 24'd1;
            for (int i = 0; i < n; i++)
                if (rem[i] != 0) all = 0;
            res.slot = run ? sel[3:0] : 4'd0;
            res.idle = !run;
            res.fin = done;
            res.all = all;
            res.now = clk_now;
            pending.push_back(res);
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result transfer with no tick pending");
                return;
            end
            exp_r = pending.pop_front();
            if (got.slot !== exp_r.slot || got.idle !== exp_r.idle || got.fin !== exp_r.fin
                || got.all !== exp_r.all || got.now !== exp_r.now) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp slot=%0d idle=%0b fin=%0b all=%0b now=%0d",
                             exp_r.slot, exp_r.idle, exp_r.fin, exp_r.all, exp_r.now);
                    $display("         got slot=%0d idle=%0b fin=%0b all=%0b now=%0d",
                             got.slot, got.idle, got.fin, got.all, got.now);
                end
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tjs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tjs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_req_type = 1'b0;
    logic [tjs_pkg::SLOT_W-1:0]     s_slot = '0;
    logic [23:0]                    s_arrival_time = '0;
    logic [15:0]                    s_run_length = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [tjs_pkg::SLOT_W-1:0]     m_running_slot;
    logic                           m_idle;
    logic                           m_job_finished;
    logic                           m_all_finished;
    logic [23:0]                    m_now_time;

    sched_scoreboard sb;
    bit              steady;
    int              out_stall;

    tick_job_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type), .s_slot(s_slot),
        .s_arrival_time(s_arrival_time), .s_run_length(s_run_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_running_slot(m_running_slot),
        .m_idle(m_idle), .m_job_finished(m_job_finished),
        .m_all_finished(m_all_finished), .m_now_time(m_now_time)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 800000);
        $display("tb_tick_job_scheduler NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_ready <= 1'b0;
        end else if (steady || $urandom_range(0, 99) < 60) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            out_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40);
        end
    end

    always @(posedge aclk) begin
        tick_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.slot = m_running_slot;
            got.idle = m_idle;
            got.fin = m_job_finished;
            got.all = m_all_finished;
            got.now = m_now_time;
            sb.check_result(got);
        end
    end

    task automatic send_item(bit rt, logic [3:0] s, logic [23:0] a, logic [15:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_slot <= s;
        s_arrival_time <= a;
        s_run_length <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(rt, s, a, r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_regs(logic [1:0] mode, logic [4:0] cnt, logic [15:0] q);
        logic [15:0] vals[3];
        vals[0] = {14'd0, mode};
        vals[1] = {11'd0, cnt};
        vals[2] = q;
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i[tjs_pkg::CFG_IDX_W-1:0];
            cfg_data <= vals[i];
            sb.set_reg(i[tjs_pkg::CFG_IDX_W-1:0], vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] job_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'd0;
        if (r < 10) return 16'hFFFF;
        return 16'($urandom_range(1, 6));
    endfunction

    initial begin
        logic [1:0]  mode;
        logic [4:0]  cnt;
        logic [15:0] q;
        logic [23:0] a;
        int          n;
        int          r;
        sb = new();
        out_stall = 0;
        steady = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole table first, with field extremes
        for (int i = 0; i < 16; i++)
            send_item(tjs_pkg::REQ_LOAD, i[3:0], (i == 15) ? 24'hFFFFFF : 24'(i),
                      (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'(i));
        repeat (4) send_item(tjs_pkg::REQ_TICK, 4'hF, 24'hFFFFFF, 16'hFFFF);
        drain();

        for (int p = 0; p < 18; p++) begin
            mode = 2'(p % 4);
            case (p)
                0: cnt = 5'd16;
                1: cnt = 5'd31;
                2: cnt = 5'd0;
                3: cnt = 5'd1;
                default: cnt = 5'($urandom_range(1, 16));
            endcase
            case (p % 6)
                1: q = 16'd0;
                3: q = 16'hFFFF;
                default: q = 16'($urandom_range(1, 4));
            endcase
            steady = (p % 5 == 4);
            write_regs(mode, cnt, q);
            n = (cnt > 16) ? 16 : cnt;
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 19);
                a = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF
                                     : 24'(sb.clk_now + $urandom_range(0, 12));
                send_item(tjs_pkg::REQ_LOAD, i[3:0], a, job_length());
            end
            for (int k = 0; k < 48; k++) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_item(tjs_pkg::REQ_TICK, 4'($urandom), 24'($urandom),
                              16'($urandom));
                else if (r < 93)
                    send_item(tjs_pkg::REQ_LOAD, 4'($urandom_range(0, 15)),
                              24'(sb.clk_now + $urandom_range(0, 6)), job_length());
                else
                    send_item(tjs_pkg::REQ_LOAD, 4'($urandom), 24'($urandom),
                              16'($urandom));
            end
            drain();
        end

        $display("covered %0d ticks and %0d loads over all four policies", sb.ticks, sb.loads);
        $display("job counts 0/1/16/31, quanta 0/1..4/65535, gaps and output stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_tick_job_scheduler OK");
        else
            $display("tb_tick_job_scheduler NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
